// File: rtl/bpp_pkg.sv
// Shared types, constants and fixed-point helpers for the Boris particle push.
// Used by every module in rtl/.
package bpp_pkg;

    localparam int SIDE_W      = 576;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 17;
    localparam int IN_W        = 384;
    localparam int OUT_W       = 160;
    localparam int CFG_W       = 31;
    localparam int ADDR_W      = 2;

    localparam logic [ADDR_W-1:0] REG_HALF_KICK = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TIME_STEP = 2'd1;

    localparam logic [48:0] NUM_2P32 = 49'h0_0001_0000_0000;
    localparam logic [48:0] NUM_2P48 = 49'h1_0000_0000_0000;
    localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;

    // first member sits in the highest bits: fields listed from the top down
    typedef struct packed {
        q_t qm;
        q_t bz;
        q_t by;
        q_t bx;
        q_t ez;
        q_t ey;
        q_t ex;
        q_t z;
        q_t y;
        q_t pz;
        q_t py;
        q_t px;
    } in_t;

    typedef struct packed {
        q_t pos_z;
        q_t pos_y;
        q_t nz;
        q_t ny;
        q_t nx;
    } out_t;

    typedef struct packed {
        q_t dq;
        q_t kx;
        q_t ky;
        q_t kz;
        q_t mx;
        q_t my;
        q_t mz;
        q_t bx;
        q_t by;
        q_t bz;
        q_t y;
        q_t z;
    } front_t;

    typedef struct packed {
        q_t m00;
        q_t m01;
        q_t m02;
        q_t m10;
        q_t m11;
        q_t m12;
        q_t m20;
        q_t m21;
        q_t m22;
        q_t mx;
        q_t my;
        q_t mz;
        q_t kx;
        q_t ky;
        q_t kz;
        q_t y;
        q_t z;
    } mid_t;

    typedef struct packed {
        q_t nx;
        q_t ny;
        q_t nz;
        q_t y;
        q_t z;
    } back_t;

    function automatic q_t sat(input logic signed [95:0] x);
        if (x > 96'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -96'sd2147483648)
            return 32'sh80000000;
        else
            return q_t'(x[31:0]);
    endfunction

    // floor(a*b / 2^16)
    function automatic logic signed [47:0] mulq(input q_t a, input q_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b);
        return p[63:16];
    endfunction

endpackage

// File: rtl/bpp_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor(sqrt(rad)).
// Carries a sideband word alongside; depends on bpp_pkg.
module bpp_isqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  logic [63:0]     rad,
    input  bpp_pkg::side_t  side_in,
    output logic            vout,
    output logic [31:0]     root,
    output bpp_pkg::side_t  side_out
);
    import bpp_pkg::*;

    logic        valid_reg [SQRT_STAGES];
    logic [63:0] rad_reg   [SQRT_STAGES];
    logic [31:0] root_reg  [SQRT_STAGES];
    logic [35:0] rem_reg   [SQRT_STAGES];
    side_t       side_reg  [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_st
        logic        v_in;
        logic [63:0] rad_in;
        logic [31:0] root_in;
        logic [35:0] rem_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        side_t       sd_in;

        if (i == 0)
        begin : g_first
            assign v_in    = vin;
            assign rad_in  = rad;
            assign root_in = '0;
            assign rem_in  = '0;
            assign sd_in   = side_in;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign sd_in   = side_reg[i-1];
        end

        assign rem_sh = {rem_in[33:0], rad_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= {rad_in[61:0], 2'b00};
                side_reg[i] <= sd_in;
                if (rem_sh >= trial)
                begin
                    rem_reg[i]  <= rem_sh - trial;
                    root_reg[i] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rem_sh;
                    root_reg[i] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign vout     = valid_reg[SQRT_STAGES-1];
    assign root     = root_reg[SQRT_STAGES-1];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

// File: rtl/bpp_recip.sv
// Pipelined restoring divider, floor(num / den) for quotients below 2^17.
// One quotient bit per stage with a sideband word; depends on bpp_pkg.
module bpp_recip (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  logic [48:0]     num,
    input  logic [63:0]     den,
    input  bpp_pkg::side_t  side_in,
    output logic            vout,
    output logic [16:0]     quo,
    output bpp_pkg::side_t  side_out
);
    import bpp_pkg::*;

    logic        valid_reg [DIV_STAGES];
    logic [48:0] rem_reg   [DIV_STAGES];
    logic [63:0] den_reg   [DIV_STAGES];
    logic [16:0] quo_reg   [DIV_STAGES];
    side_t       side_reg  [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_st
        localparam int B = DIV_STAGES - 1 - i;
        logic        v_in;
        logic [48:0] rem_in;
        logic [63:0] den_in;
        logic [16:0] quo_in;
        side_t       sd_in;
        logic [79:0] dsh;
        logic        take;

        if (i == 0)
        begin : g_first
            assign v_in   = vin;
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign sd_in  = side_in;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign sd_in  = side_reg[i-1];
        end

        assign dsh  = 80'(den_in) << B;
        assign take = 80'(rem_in) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i]  <= den_in;
                side_reg[i] <= sd_in;
                quo_reg[i]  <= {quo_in[15:0], take};
                rem_reg[i]  <= take ? (rem_in - dsh[48:0]) : rem_in;
            end
        end
    end

    assign vout     = valid_reg[DIV_STAGES-1];
    assign quo      = quo_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// File: rtl/relativistic_boris_particle_push_top.sv
// Relativistic Boris push: half kick, tau rotation, half kick, half-step advance.
// Depends on bpp_pkg, bpp_isqrt and bpp_recip.
//
// Usage:
//   Slave stream (s_*) takes one particle per beat; master stream (m_*) gives
//   one pushed particle per beat, in input order. All values signed Q16.16.
//   cfg_we/cfg_addr/cfg_data write half_kick_scale (0) and time_step (1);
//   write them only while the pipeline is empty.
//   Throughput: one beat per cycle while the output is not stalled. Most of
//   the depth comes from two inverse square roots (32-stage root plus
//   17-stage divider each) and the 17-stage tau divider.
//   The whole pipeline advances on one enable: it moves whenever the output
//   register is empty or taken, so s_tready follows m_tready when the output
//   holds a beat. A stall freezes every stage; nothing is lost or repeated.
//   Reset clears all valid bits and both config registers to zero.
module relativistic_boris_particle_push_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mom_x, mom_y, mom_z, pos_y, pos_z, efield_x/y/z, bfield_x/y/z,
    // charge_mass_ratio; 32 bits each from bit 0 up
    input  logic [bpp_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_mom_x, new_mom_y, new_mom_z, new_pos_y, new_pos_z; 32 bits each
    output logic [bpp_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_we,
    input  logic [bpp_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [bpp_pkg::CFG_W-1:0]     cfg_data
);
    import bpp_pkg::*;

    logic en;

    logic [CFG_W-1:0] hks_reg;
    logic [CFG_W-1:0] ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hks_reg <= '0;
            ts_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HALF_KICK: hks_reg <= cfg_data;
                REG_TIME_STEP: ts_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front half kick
    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    in_t   a1_reg, a2_reg, a3_reg, a4_reg, a5_reg;
    q_t    dq2_reg, dq3_reg, dq4_reg, dq5_reg;
    q_t    kx3_reg, ky3_reg, kz3_reg, kx4_reg, ky4_reg, kz4_reg;
    q_t    kx5_reg, ky5_reg, kz5_reg;
    q_t    mx4_reg, my4_reg, mz4_reg, mx5_reg, my5_reg, mz5_reg;
    prod_t sx5_reg, sy5_reg, sz5_reg;
    logic [63:0] rad6_reg;
    front_t      fr6_reg;

    // first inverse root
    logic        vq1, vr1;
    logic [31:0] q1;
    logic [16:0] rinv1;
    side_t       sd_q1, sd_r1;
    front_t      fr_r1;

    // tau and matrix
    logic   v7_reg, v8_reg, v9_reg, v10_reg;
    front_t fr7_reg, fr8_reg, fr9_reg;
    q_t     root7_reg;
    q_t     tx8_reg, ty8_reg, tz8_reg, tx9_reg, ty9_reg, tz9_reg;
    prod_t  pxx9_reg, pyy9_reg, pzz9_reg, pxy9_reg, pxz9_reg, pyz9_reg;
    logic [63:0] rad10_reg;
    mid_t   mid10_reg;

    logic        vt;
    logic [16:0] tau;
    side_t       sd_t;
    mid_t        mid_t2;

    // rotation and second kick
    logic v11_reg, v12_reg, v13_reg, v14_reg, v15_reg, v16_reg;
    logic signed [47:0] pr11_reg [9];
    mid_t   mid11_reg;
    logic [16:0] tau11_reg, tau12_reg;
    q_t     dx12_reg, dy12_reg, dz12_reg;
    q_t     kx12_reg, ky12_reg, kz12_reg, kx13_reg, ky13_reg, kz13_reg;
    q_t     y12_reg, z12_reg, y13_reg, z13_reg;
    q_t     rx13_reg, ry13_reg, rz13_reg;
    back_t  bk14_reg, bk15_reg;
    prod_t  sx15_reg, sy15_reg, sz15_reg;
    logic [63:0] rad16_reg;
    back_t  bk16_reg;

    // second inverse root
    logic        vq2, vr2;
    logic [31:0] q2;
    logic [16:0] g2;
    side_t       sd_q2, sd_r2;
    back_t       bk_r2;

    // velocity and position
    logic  v17_reg, v18_reg, v19_reg;
    q_t    vy17_reg, vz17_reg;
    back_t bk17_reg, bk18_reg;
    prod_t dy18_reg, dz18_reg;
    out_t  out19_reg;

    assign en       = !v19_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = v19_reg;
    assign m_tdata  = out19_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
            v17_reg <= 1'b0;
            v18_reg <= 1'b0;
            v19_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= vr1;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= vt;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            v16_reg <= v15_reg;
            v17_reg <= vr2;
            v18_reg <= v17_reg;
            v19_reg <= v18_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= in_t'(s_tdata);

            a2_reg  <= a1_reg;
            dq2_reg <= sat(96'(mulq(a1_reg.qm, q_t'({1'b0, hks_reg}))));

            a3_reg  <= a2_reg;
            dq3_reg <= dq2_reg;
            kx3_reg <= sat(96'(mulq(dq2_reg, a2_reg.ex)));
            ky3_reg <= sat(96'(mulq(dq2_reg, a2_reg.ey)));
            kz3_reg <= sat(96'(mulq(dq2_reg, a2_reg.ez)));

            a4_reg  <= a3_reg;
            dq4_reg <= dq3_reg;
            kx4_reg <= kx3_reg;
            ky4_reg <= ky3_reg;
            kz4_reg <= kz3_reg;
            mx4_reg <= sat(96'(a3_reg.px) + 96'(kx3_reg));
            my4_reg <= sat(96'(a3_reg.py) + 96'(ky3_reg));
            mz4_reg <= sat(96'(a3_reg.pz) + 96'(kz3_reg));

            a5_reg  <= a4_reg;
            dq5_reg <= dq4_reg;
            kx5_reg <= kx4_reg;
            ky5_reg <= ky4_reg;
            kz5_reg <= kz4_reg;
            mx5_reg <= mx4_reg;
            my5_reg <= my4_reg;
            mz5_reg <= mz4_reg;
            sx5_reg <= prod_t'(mx4_reg) * prod_t'(mx4_reg);
            sy5_reg <= prod_t'(my4_reg) * prod_t'(my4_reg);
            sz5_reg <= prod_t'(mz4_reg) * prod_t'(mz4_reg);

            rad6_reg   <= ONE_Q32 + 64'(unsigned'(sx5_reg)) + 64'(unsigned'(sy5_reg))
                          + 64'(unsigned'(sz5_reg));
            fr6_reg.dq <= dq5_reg;
            fr6_reg.kx <= kx5_reg;
            fr6_reg.ky <= ky5_reg;
            fr6_reg.kz <= kz5_reg;
            fr6_reg.mx <= mx5_reg;
            fr6_reg.my <= my5_reg;
            fr6_reg.mz <= mz5_reg;
            fr6_reg.bx <= a5_reg.bx;
            fr6_reg.by <= a5_reg.by;
            fr6_reg.bz <= a5_reg.bz;
            fr6_reg.y  <= a5_reg.y;
            fr6_reg.z  <= a5_reg.z;

            fr7_reg   <= fr_r1;
            root7_reg <= sat(96'(mulq(fr_r1.dq, q_t'({15'b0, rinv1}))));

            fr8_reg <= fr7_reg;
            tx8_reg <= sat(96'(mulq(fr7_reg.bx, root7_reg)));
            ty8_reg <= sat(96'(mulq(fr7_reg.by, root7_reg)));
            tz8_reg <= sat(96'(mulq(fr7_reg.bz, root7_reg)));

            fr9_reg  <= fr8_reg;
            tx9_reg  <= tx8_reg;
            ty9_reg  <= ty8_reg;
            tz9_reg  <= tz8_reg;
            pxx9_reg <= prod_t'(tx8_reg) * prod_t'(tx8_reg);
            pyy9_reg <= prod_t'(ty8_reg) * prod_t'(ty8_reg);
            pzz9_reg <= prod_t'(tz8_reg) * prod_t'(tz8_reg);
            pxy9_reg <= prod_t'(tx8_reg) * prod_t'(ty8_reg);
            pxz9_reg <= prod_t'(tx8_reg) * prod_t'(tz8_reg);
            pyz9_reg <= prod_t'(ty8_reg) * prod_t'(tz8_reg);

            rad10_reg <= ONE_Q32 + 64'(unsigned'(pxx9_reg)) + 64'(unsigned'(pyy9_reg))
                         + 64'(unsigned'(pzz9_reg));
            mid10_reg.m00 <= sat(96'sd65536 + 96'(pxx9_reg >>> 16) - 96'(pyy9_reg >>> 16)
                                 - 96'(pzz9_reg >>> 16));
            mid10_reg.m11 <= sat(96'sd65536 - 96'(pxx9_reg >>> 16) + 96'(pyy9_reg >>> 16)
                                 - 96'(pzz9_reg >>> 16));
            mid10_reg.m22 <= sat(96'sd65536 - 96'(pxx9_reg >>> 16) - 96'(pyy9_reg >>> 16)
                                 + 96'(pzz9_reg >>> 16));
            mid10_reg.m01 <= sat(96'(pxy9_reg >>> 15) + 96'(tz9_reg) + 96'(tz9_reg));
            mid10_reg.m02 <= sat(96'(pxz9_reg >>> 15) - 96'(ty9_reg) - 96'(ty9_reg));
            mid10_reg.m10 <= sat(96'(pxy9_reg >>> 15) - 96'(tz9_reg) - 96'(tz9_reg));
            mid10_reg.m12 <= sat(96'(pyz9_reg >>> 15) + 96'(tx9_reg) + 96'(tx9_reg));
            mid10_reg.m20 <= sat(96'(pxz9_reg >>> 15) + 96'(ty9_reg) + 96'(ty9_reg));
            mid10_reg.m21 <= sat(96'(pyz9_reg >>> 15) - 96'(tx9_reg) - 96'(tx9_reg));
            mid10_reg.mx  <= fr9_reg.mx;
            mid10_reg.my  <= fr9_reg.my;
            mid10_reg.mz  <= fr9_reg.mz;
            mid10_reg.kx  <= fr9_reg.kx;
            mid10_reg.ky  <= fr9_reg.ky;
            mid10_reg.kz  <= fr9_reg.kz;
            mid10_reg.y   <= fr9_reg.y;
            mid10_reg.z   <= fr9_reg.z;

            mid11_reg   <= mid_t2;
            tau11_reg   <= tau;
            pr11_reg[0] <= mulq(mid_t2.m00, mid_t2.mx);
            pr11_reg[1] <= mulq(mid_t2.m01, mid_t2.my);
            pr11_reg[2] <= mulq(mid_t2.m02, mid_t2.mz);
            pr11_reg[3] <= mulq(mid_t2.m10, mid_t2.mx);
            pr11_reg[4] <= mulq(mid_t2.m11, mid_t2.my);
            pr11_reg[5] <= mulq(mid_t2.m12, mid_t2.mz);
            pr11_reg[6] <= mulq(mid_t2.m20, mid_t2.mx);
            pr11_reg[7] <= mulq(mid_t2.m21, mid_t2.my);
            pr11_reg[8] <= mulq(mid_t2.m22, mid_t2.mz);

            dx12_reg  <= sat(96'(pr11_reg[0]) + 96'(pr11_reg[1]) + 96'(pr11_reg[2]));
            dy12_reg  <= sat(96'(pr11_reg[3]) + 96'(pr11_reg[4]) + 96'(pr11_reg[5]));
            dz12_reg  <= sat(96'(pr11_reg[6]) + 96'(pr11_reg[7]) + 96'(pr11_reg[8]));
            tau12_reg <= tau11_reg;
            kx12_reg  <= mid11_reg.kx;
            ky12_reg  <= mid11_reg.ky;
            kz12_reg  <= mid11_reg.kz;
            y12_reg   <= mid11_reg.y;
            z12_reg   <= mid11_reg.z;

            rx13_reg <= sat(96'(mulq(dx12_reg, q_t'({15'b0, tau12_reg}))));
            ry13_reg <= sat(96'(mulq(dy12_reg, q_t'({15'b0, tau12_reg}))));
            rz13_reg <= sat(96'(mulq(dz12_reg, q_t'({15'b0, tau12_reg}))));
            kx13_reg <= kx12_reg;
            ky13_reg <= ky12_reg;
            kz13_reg <= kz12_reg;
            y13_reg  <= y12_reg;
            z13_reg  <= z12_reg;

            bk14_reg.nx <= sat(96'(rx13_reg) + 96'(kx13_reg));
            bk14_reg.ny <= sat(96'(ry13_reg) + 96'(ky13_reg));
            bk14_reg.nz <= sat(96'(rz13_reg) + 96'(kz13_reg));
            bk14_reg.y  <= y13_reg;
            bk14_reg.z  <= z13_reg;

            bk15_reg <= bk14_reg;
            sx15_reg <= prod_t'(bk14_reg.nx) * prod_t'(bk14_reg.nx);
            sy15_reg <= prod_t'(bk14_reg.ny) * prod_t'(bk14_reg.ny);
            sz15_reg <= prod_t'(bk14_reg.nz) * prod_t'(bk14_reg.nz);

            rad16_reg <= ONE_Q32 + 64'(unsigned'(sx15_reg)) + 64'(unsigned'(sy15_reg))
                         + 64'(unsigned'(sz15_reg));
            bk16_reg  <= bk15_reg;

            bk17_reg <= bk_r2;
            vy17_reg <= sat(96'(mulq(bk_r2.ny, q_t'({15'b0, g2}))));
            vz17_reg <= sat(96'(mulq(bk_r2.nz, q_t'({15'b0, g2}))));

            bk18_reg <= bk17_reg;
            dy18_reg <= prod_t'(vy17_reg) * prod_t'(q_t'({1'b0, ts_reg}));
            dz18_reg <= prod_t'(vz17_reg) * prod_t'(q_t'({1'b0, ts_reg}));

            out19_reg.nx    <= bk18_reg.nx;
            out19_reg.ny    <= bk18_reg.ny;
            out19_reg.nz    <= bk18_reg.nz;
            out19_reg.pos_y <= sat(96'(bk18_reg.y) + 96'(dy18_reg >>> 17));
            out19_reg.pos_z <= sat(96'(bk18_reg.z) + 96'(dz18_reg >>> 17));
        end
    end

    bpp_isqrt u_sqrt1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (v6_reg),
        .rad      (rad6_reg),
        .side_in  (side_t'(fr6_reg)),
        .vout     (vq1),
        .root     (q1),
        .side_out (sd_q1)
    );

    bpp_recip u_recip1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (vq1),
        .num      (NUM_2P32),
        .den      (64'(q1)),
        .side_in  (sd_q1),
        .vout     (vr1),
        .quo      (rinv1),
        .side_out (sd_r1)
    );

    assign fr_r1 = front_t'(sd_r1[$bits(front_t)-1:0]);

    bpp_recip u_tau (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (v10_reg),
        .num      (NUM_2P48),
        .den      (rad10_reg),
        .side_in  (side_t'(mid10_reg)),
        .vout     (vt),
        .quo      (tau),
        .side_out (sd_t)
    );

    assign mid_t2 = mid_t'(sd_t[$bits(mid_t)-1:0]);

    bpp_isqrt u_sqrt2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (v16_reg),
        .rad      (rad16_reg),
        .side_in  (side_t'(bk16_reg)),
        .vout     (vq2),
        .root     (q2),
        .side_out (sd_q2)
    );

    bpp_recip u_recip2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (vq2),
        .num      (NUM_2P32),
        .den      (64'(q2)),
        .side_in  (sd_q2),
        .vout     (vr2),
        .quo      (g2),
        .side_out (sd_r2)
    );

    assign bk_r2 = back_t'(sd_r2[$bits(back_t)-1:0]);

endmodule
